@@ hw/rtl/pmt_pkg.sv @@
// Proximity metrics tracker package: widths, limits, controller states,
// the command/status structs between controller and datapath, and the table entry.
// No dependencies.
package pmt_pkg;

	localparam int DIST_W = 24;
	localparam int CNT_W  = 16;
	localparam int RAD_W  = 16;
	localparam int SLOT_W = 5;
	localparam int ROOT_W = 25;
	localparam int SQ_W   = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 3;
	localparam int STEP_W = $clog2(ROOT_W);

	localparam logic [DIST_W-1:0] DIST_MAX   = '1;
	localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
	localparam logic [RAD_W-1:0]  RADIUS_RST = RAD_W'(64);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SUM,
		ST_ROOT,
		ST_DIST,
		ST_EMIT,
		ST_WALK,
		ST_DRAIN,
		ST_EMPTY
	} pmt_state_t;

	typedef struct packed {
		logic load;
		logic sq_x;
		logic sq_y;
		logic sum;
		logic root_step;
		logic dist_load;
		logic emit;
		logic walk;
		logic drain;
		logic empty;
	} pmt_cmd_t;

	typedef struct packed {
		logic any_seen;
		logic root_done;
		logic walk_done;
	} pmt_stat_t;

	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [DIST_W-1:0] min_dist;
		logic [DIST_W-1:0] last_dist;
	} pmt_entry_t;

endpackage

@@ hw/rtl/pmt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/pmt_ctrl.sv @@
// Controller state machine of the proximity metrics tracker.
// Depends on pmt_pkg (states, command and status structs).
module pmt_ctrl import pmt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      req_type,
	input  pmt_stat_t stat,
	output pmt_cmd_t  cmd,
	output logic      busy
);

	pmt_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (!req_type) begin
						state_n = ST_SQX;
					end else if (stat.any_seen) begin
						state_n = ST_WALK;
					end else begin
						state_n = ST_EMPTY;
					end
				end
			end
			ST_SQX: begin
				cmd.sq_x = 1'b1;
				state_n  = ST_SQY;
			end
			ST_SQY: begin
				cmd.sq_y = 1'b1;
				state_n  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_n = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (stat.root_done) begin
					state_n = ST_DIST;
				end
			end
			ST_DIST: begin
				cmd.dist_load = 1'b1;
				state_n       = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_n  = ST_IDLE;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_done) begin
					state_n = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.drain = 1'b1;
				state_n   = ST_IDLE;
			end
			ST_EMPTY: begin
				cmd.empty = 1'b1;
				state_n   = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

@@ hw/rtl/pmt_dp.sv @@
// Datapath: offsets, shared squarer, bit-serial square root, per-track update,
// report walk and result registers. Depends on pmt_pkg; table RAM sits outside.
module pmt_dp import pmt_pkg::*; #(
	parameter int MAX_TRACKS = 32,
	parameter int COORD_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pmt_cmd_t                            cmd,
	output pmt_stat_t                           stat,
	input  logic [SLOT_W-1:0]                   track_index,
	input  logic signed [COORD_BITS-1:0]        robot_x,
	input  logic signed [COORD_BITS-1:0]        robot_y,
	input  logic signed [COORD_BITS-1:0]        human_x,
	input  logic signed [COORD_BITS-1:0]        human_y,
	input  logic [RAD_W-1:0]                    human_radius,
	input  logic                                cfg_we,
	input  logic [RAD_W-1:0]                    cfg_wdata,
	output logic                                ram_we,
	output logic [((MAX_TRACKS < 32 ? MAX_TRACKS : 32) > 1 ?
		$clog2(MAX_TRACKS < 32 ? MAX_TRACKS : 32) : 1)-1:0] ram_waddr,
	output pmt_entry_t                          ram_wdata,
	output logic                                ram_re,
	output logic [((MAX_TRACKS < 32 ? MAX_TRACKS : 32) > 1 ?
		$clog2(MAX_TRACKS < 32 ? MAX_TRACKS : 32) : 1)-1:0] ram_raddr,
	input  pmt_entry_t                          ram_rdata,
	output logic                                strobe,
	output logic                                valid_res,
	output logic [SLOT_W-1:0]                   track_slot,
	output logic                                collided,
	output logic [DIST_W-1:0]                   distance,
	output logic [DIST_W-1:0]                   min_distance,
	output logic [CNT_W-1:0]                    collision_count,
	output logic                                last
);

	localparam int TD = (MAX_TRACKS < 32) ? MAX_TRACKS : 32;
	localparam int AW = (TD > 1) ? $clog2(TD) : 1;
	localparam int MW = (COORD_BITS > DIST_W) ? COORD_BITS : DIST_W;

	// configuration
	logic [RAD_W-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// offsets
	logic [COORD_BITS:0] dx_diff, dy_diff, dx_neg, dy_neg;
	logic [MW-1:0]       dx_mag, dy_mag;

	assign dx_diff = {human_x[COORD_BITS-1], human_x} - {robot_x[COORD_BITS-1], robot_x};
	assign dy_diff = {human_y[COORD_BITS-1], human_y} - {robot_y[COORD_BITS-1], robot_y};
	assign dx_neg  = (~dx_diff) + 1'b1;
	assign dy_neg  = (~dy_diff) + 1'b1;
	assign dx_mag  = MW'(dx_diff[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx_diff[COORD_BITS-1:0]);
	assign dy_mag  = MW'(dy_diff[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy_diff[COORD_BITS-1:0]);

	logic [DIST_W-1:0] dx_q, dy_q;
	logic              sat_q;
	logic [RAD_W-1:0]  hrad_q;
	logic [SLOT_W-1:0] slot_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q   <= dx_mag[DIST_W-1:0];
			dy_q   <= dy_mag[DIST_W-1:0];
			sat_q  <= (dx_mag > MW'(DIST_MAX)) || (dy_mag > MW'(DIST_MAX));
			hrad_q <= human_radius;
			slot_q <= track_index;
		end
	end

	// shared squarer and sum
	logic [DIST_W-1:0]   mul_in;
	logic [2*DIST_W-1:0] prod_n, prod_q;
	logic [SQ_W-1:0]     rad_q;

	assign mul_in = cmd.sq_y ? dy_q : dx_q;
	assign prod_n = mul_in * mul_in;

	// bit-serial root, one result bit per cycle
	logic [REM_W-1:0]  rem_q, rem_cat, trial;
	logic [ROOT_W-1:0] root_q;
	logic [STEP_W-1:0] step_q;
	logic [DIST_W-1:0] dist_q;

	assign rem_cat = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
	assign trial   = REM_W'({root_q, 2'b01});

	always_ff @(posedge clk) begin
		if (cmd.sq_x || cmd.sq_y) begin
			prod_q <= prod_n;
		end
		if (cmd.sq_y) begin
			rad_q <= SQ_W'(prod_q);
		end else if (cmd.sum) begin
			rad_q <= rad_q + SQ_W'(prod_q);
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[SQ_W-3:0], 2'b00};
		end
		if (cmd.sum) begin
			rem_q  <= '0;
			root_q <= '0;
			step_q <= '0;
		end else if (cmd.root_step) begin
			step_q <= step_q + 1'b1;
			if (rem_cat >= trial) begin
				rem_q  <= rem_cat - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_cat;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.dist_load) begin
			dist_q <= (sat_q || root_q[ROOT_W-1]) ? DIST_MAX : root_q[DIST_W-1:0];
		end
	end

	// per-track update
	logic [TD-1:0]     seen_q;
	logic              in_range, seen_old, coll;
	logic [RAD_W:0]    reach;
	logic [CNT_W-1:0]  old_cnt, cnt_new;
	logic [DIST_W-1:0] min_new;

	assign in_range = (int'(slot_q) < MAX_TRACKS);
	assign seen_old = in_range && seen_q[slot_q[AW-1:0]];
	assign reach    = {1'b0, radius_q} + {1'b0, hrad_q};
	assign coll     = (DIST_W'(reach) >= dist_q);
	assign old_cnt  = seen_old ? ram_rdata.cnt : '0;
	assign cnt_new  = (coll && (old_cnt != CNT_MAX)) ? old_cnt + 1'b1 : old_cnt;
	assign min_new  = (seen_old && (ram_rdata.min_dist < dist_q)) ? ram_rdata.min_dist : dist_q;

	assign ram_we             = cmd.emit && in_range;
	assign ram_waddr          = slot_q[AW-1:0];
	assign ram_wdata.cnt      = cnt_new;
	assign ram_wdata.min_dist = min_new;
	assign ram_wdata.last_dist = dist_q;

	// report walk
	logic [AW-1:0] walk_q, walk_s1;
	logic          vld_s1, rpt_hit, above;

	assign ram_re    = cmd.load || cmd.walk;
	assign ram_raddr = cmd.walk ? walk_q : track_index[AW-1:0];
	assign rpt_hit   = vld_s1 && seen_q[walk_s1];

	always_comb begin
		above = 1'b0;
		for (int k = 0; k < TD; k++) begin
			if (seen_q[k] && (k > int'(walk_s1))) begin
				above = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.walk;
			if (cmd.drain) begin
				seen_q <= '0;
			end else if (ram_we) begin
				seen_q[slot_q[AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			walk_q <= '0;
		end else if (cmd.walk) begin
			walk_q <= walk_q + 1'b1;
		end
		walk_s1 <= walk_q;
	end

	assign stat.any_seen  = |seen_q;
	assign stat.root_done = (step_q == STEP_W'(ROOT_W - 1));
	assign stat.walk_done = (walk_q == AW'(TD - 1));

	// result registers
	logic strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit || cmd.empty || rpt_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			valid_res       <= 1'b1;
			track_slot      <= slot_q;
			collided        <= coll;
			distance        <= dist_q;
			min_distance    <= '0;
			collision_count <= in_range ? cnt_new : '0;
			last            <= 1'b1;
		end else if (cmd.empty) begin
			valid_res       <= 1'b0;
			track_slot      <= '0;
			collided        <= 1'b0;
			distance        <= '0;
			min_distance    <= '0;
			collision_count <= '0;
			last            <= 1'b1;
		end else if (rpt_hit) begin
			valid_res       <= 1'b1;
			track_slot      <= SLOT_W'(walk_s1);
			collided        <= 1'b0;
			distance        <= ram_rdata.last_dist;
			min_distance    <= ram_rdata.min_dist;
			collision_count <= ram_rdata.cnt;
			last            <= !above;
		end
	end

	assign strobe = strobe_q;

endmodule

@@ hw/rtl/proximity_metrics_tracker.sv @@
// Channel   | Signals                                            | Handshake
// ----------+----------------------------------------------------+---------------------------
// request   | req_type track_index robot_x/y human_x/y human_radius | start & !busy
// result    | valid_res track_slot collided distance min_distance  | strobe, one cycle
//           | collision_count last                               |
// config    | cfg_wdata (robot_radius)                           | cfg_we
//
// A sample item keeps busy high through squaring x then y, a sum, 25 root bits
// one per cycle, then distance and table update; its result strobes in the next cycle.
// A report walks the track table one slot a cycle through the RAM read port:
// MAX_TRACKS (at most 32) slots, results strobing as seen slots come out.
// Reset clears the seen flags and sets the radius to 64.
// The receiver cannot stall; one item is in work at a time.
module proximity_metrics_tracker import pmt_pkg::*; #(
	parameter int MAX_TRACKS = 32,
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [SLOT_W-1:0]            track_index,
	input  logic signed [COORD_BITS-1:0] robot_x,
	input  logic signed [COORD_BITS-1:0] robot_y,
	input  logic signed [COORD_BITS-1:0] human_x,
	input  logic signed [COORD_BITS-1:0] human_y,
	input  logic [RAD_W-1:0]             human_radius,
	input  logic                         cfg_we,
	input  logic [RAD_W-1:0]             cfg_wdata,
	output logic                         strobe,
	output logic                         valid_res,
	output logic [SLOT_W-1:0]            track_slot,
	output logic                         collided,
	output logic [DIST_W-1:0]            distance,
	output logic [DIST_W-1:0]            min_distance,
	output logic [CNT_W-1:0]             collision_count,
	output logic                         last
);

	localparam int TD = (MAX_TRACKS < 32) ? MAX_TRACKS : 32;
	localparam int AW = (TD > 1) ? $clog2(TD) : 1;

	pmt_cmd_t   cmd;
	pmt_stat_t  stat;
	logic       ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	pmt_entry_t ram_wdata, ram_rdata;

	pmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	pmt_dp #(
		.MAX_TRACKS (MAX_TRACKS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.track_index     (track_index),
		.robot_x         (robot_x),
		.robot_y         (robot_y),
		.human_x         (human_x),
		.human_y         (human_y),
		.human_radius    (human_radius),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_re          (ram_re),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.strobe          (strobe),
		.valid_res       (valid_res),
		.track_slot      (track_slot),
		.collided        (collided),
		.distance        (distance),
		.min_distance    (min_distance),
		.collision_count (collision_count),
		.last            (last)
	);

	pmt_ram #(
		.WIDTH ($bits(pmt_entry_t)),
		.DEPTH (TD)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

@@ hw/rtl/pmt_chk.sv @@
// Port-level checker for the proximity metrics tracker, bound to the top level.
// Depends on pmt_pkg for field widths.
module pmt_chk import pmt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              strobe,
	input logic              valid_res,
	input logic              collided,
	input logic [DIST_W-1:0] distance,
	input logic [DIST_W-1:0] min_distance,
	input logic [CNT_W-1:0]  collision_count,
	input logic              last
);

	// every accepted item raises busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// only the final result of an item may appear once the block is idle
	a_more_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final result while idle");

	a_empty_report: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !valid_res |-> last && !collided && (distance == '0) &&
			(collision_count == '0))
		else $error("empty report carries data");

	a_min_le_dist: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && valid_res |-> min_distance <= distance)
		else $error("minimum distance above reported distance");

endmodule

bind proximity_metrics_tracker pmt_chk u_pmt_chk (.*);
